FILE: design/rc5hf_pkg.sv
package rc5hf_pkg;

    localparam int HALF_BITS     = 28;
    localparam int OUT_W         = 28;
    localparam int TICKS_W       = 16;
    localparam int IDX_W         = $clog2(HALF_BITS + 1);
    localparam int FIDX_W        = $clog2(HALF_BITS);
    localparam int PAIRS         = HALF_BITS / 2;
    localparam int PAD_W         = (HALF_BITS > OUT_W) ? HALF_BITS : OUT_W;
    localparam int FIRST_SAMPLE  = 2;

    localparam logic [TICKS_W-1:0] HALF_BIT_TICKS_RST = TICKS_W'(889);

    typedef logic [HALF_BITS-1:0] t_frame;
    typedef logic [OUT_W-1:0]     t_half_bits;

    typedef struct packed {
        logic       valid;
        t_half_bits half_bits;
    } t_result;

    function automatic logic frame_ok(input t_frame f);
        logic ok;
        ok = 1'b1;
        for (int p = 0; p < PAIRS; p++) begin
            ok = ok & (f[2*p] ^ f[2*p+1]);
        end
        return ok;
    endfunction

    function automatic t_half_bits frame_out(input t_frame f);
        logic [PAD_W-1:0] padded;
        padded = PAD_W'(f);
        return padded[OUT_W-1:0];
    endfunction

endpackage

FILE: design/rc5hf_pin_if.sv
interface rc5hf_pin_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

FILE: design/rc5hf_frame_if.sv
interface rc5hf_frame_if;
    import rc5hf_pkg::*;

    logic       valid;
    logic       ready;
    t_half_bits half_bits;

    modport source (output valid, output half_bits, input ready);
    modport sink   (input valid, input half_bits, output ready);
endinterface

FILE: design/rc5hf_cfg_if.sv
interface rc5hf_cfg_if;
    import rc5hf_pkg::*;

    logic               valid;
    logic               ready;
    logic [TICKS_W-1:0] half_bit_ticks;

    modport source (output valid, output half_bit_ticks, input ready);
    modport sink   (input valid, input half_bit_ticks, output ready);
endinterface

FILE: design/rc5hf_capture.sv
module rc5hf_capture (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_pin_level,
    input  logic [rc5hf_pkg::TICKS_W-1:0]   i_half_bit_ticks,
    output rc5hf_pkg::t_result              o_result
);
    import rc5hf_pkg::*;

    logic               r_capturing, n_capturing;
    logic [TICKS_W-1:0] r_tick_count, n_tick_count;
    logic [IDX_W-1:0]   r_half_index, n_half_index;
    t_frame             r_frame_bits, n_frame_bits;

    logic [TICKS_W-1:0] period;
    logic [TICKS_W-1:0] tick_inc;
    logic [IDX_W-1:0]   idx_inc;
    t_frame             sampled;

    assign period   = (i_half_bit_ticks == '0) ? TICKS_W'(1) : i_half_bit_ticks;
    assign tick_inc = r_tick_count + TICKS_W'(1);
    assign idx_inc  = r_half_index + IDX_W'(1);

    always_comb begin
        sampled = r_frame_bits;
        sampled[r_half_index[FIDX_W-1:0]] = r_frame_bits[r_half_index[FIDX_W-1:0]] | i_pin_level;
    end

    always_comb begin
        n_capturing        = r_capturing;
        n_tick_count       = r_tick_count;
        n_half_index       = r_half_index;
        n_frame_bits       = r_frame_bits;
        o_result.valid     = 1'b0;
        o_result.half_bits = frame_out(sampled);
        if (i_accept) begin
            if (!r_capturing) begin
                if (!i_pin_level) begin
                    n_capturing  = 1'b1;
                    n_frame_bits = HALF_BITS'(1);
                    n_tick_count = '0;
                    n_half_index = IDX_W'(FIRST_SAMPLE);
                end
            end else if (tick_inc < period) begin
                n_tick_count = tick_inc;
            end else begin
                n_tick_count = '0;
                if (idx_inc < IDX_W'(HALF_BITS)) begin
                    n_half_index = idx_inc;
                    n_frame_bits = sampled;
                end else begin
                    n_capturing    = 1'b0;
                    n_half_index   = '0;
                    n_frame_bits   = HALF_BITS'(1);
                    o_result.valid = frame_ok(sampled);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing  <= 1'b0;
            r_tick_count <= '0;
            r_half_index <= '0;
            r_frame_bits <= HALF_BITS'(1);
        end else begin
            r_capturing  <= n_capturing;
            r_tick_count <= n_tick_count;
            r_half_index <= n_half_index;
            r_frame_bits <= n_frame_bits;
        end
    end

    a_result_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (r_capturing && r_half_index == IDX_W'(HALF_BITS - 1)))
        else $error("result outside last half-bit sample");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_capturing |-> (r_half_index >= IDX_W'(FIRST_SAMPLE)
                         && r_half_index < IDX_W'(HALF_BITS)))
        else $error("half-bit index out of range while capturing");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_capturing |-> (r_half_index == '0 && r_frame_bits == HALF_BITS'(1)))
        else $error("idle state not clean");

endmodule

FILE: design/rc5_halfbit_frame_capture_core.sv
// A frame whose half-bit pairs all differ is registered on the pin transaction of its last half-bit.
// Throughput: one pin transaction per cycle while pin ready is high; the timing counter moves only on transactions.
// Two result slots (output register and skid); pin ready drops only while both are full.
// Reset: synchronous, active low; returns to idle, clears results, half_bit_ticks to 889.
module rc5_halfbit_frame_capture_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rc5hf_pin_if.sink       i_pin,
    rc5hf_cfg_if.sink       i_cfg,
    rc5hf_frame_if.source   o_frame
);
    import rc5hf_pkg::*;

    logic [TICKS_W-1:0] r_half_bit_ticks;
    logic               r_out_valid;
    t_half_bits         r_out_data;
    logic               r_skid_valid;
    t_half_bits         r_skid_data;

    t_result            result;
    logic               accept;
    logic               pop;

    assign i_cfg.ready     = 1'b1;
    assign i_pin.ready     = !r_skid_valid;
    assign accept          = i_pin.valid && i_pin.ready;
    assign pop             = r_out_valid && o_frame.ready;
    assign o_frame.valid   = r_out_valid;
    assign o_frame.half_bits = r_out_data;

    rc5hf_capture u_capture (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_pin_level      (i_pin.pin_level),
        .i_half_bit_ticks (r_half_bit_ticks),
        .o_result         (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bit_ticks <= HALF_BIT_TICKS_RST;
        end else if (i_cfg.valid) begin
            r_half_bit_ticks <= i_cfg.half_bit_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid && pop) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else if (result.valid) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid && pop) begin
            r_out_data <= r_skid_data;
        end else if (result.valid) begin
            if (!r_out_valid || pop) begin
                r_out_data <= result.half_bits;
            end else begin
                r_skid_data <= result.half_bits;
            end
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot full with output register empty");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(result.valid && r_skid_valid))
        else $error("result produced with both slots full");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && pop) |=> (r_out_valid && !r_skid_valid))
        else $error("skid slot did not move to output register");

endmodule
